@@ hdl/kwmh_pkg.sv @@
// ----------------------------------------------------------------------------
// kwmh_pkg
// Shared types and fixed widths for the k-way merge heap.
// ----------------------------------------------------------------------------
`default_nettype none

package kwmh_pkg;

    localparam int VALUE_W    = 32;
    localparam int OUT_LANE_W = 4;
    localparam int CFG_W      = 5;

    localparam logic [CFG_W-1:0]   LANE_COUNT_RST = CFG_W'(16);
    localparam logic [VALUE_W-1:0] SIGN_FLIP      = 32'h8000_0000;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,   // wait for an item
        S_UP,     // sift-up compare against parent
        S_PLACE,  // drop held entry into the hole
        S_POP,    // read root and last entry
        S_TOP,    // emit root, start sift-down
        S_DN      // sift-down compare against children
    } t_state;

endpackage

`default_nettype wire

@@ hdl/k_way_merge_heap.sv @@
// ----------------------------------------------------------------------------
// k_way_merge_heap
// Merges sorted lane streams into one ascending stream through a min-heap.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are taken when i_start is high and o_busy is low. After the
//   merge starts, each item loads one lane head in lane order; no result comes
//   out until the last head (lane_count heads) is in. Then a result is emitted
//   and every following item is the refill for o_lane_res of the last result.
//   A result shows for one cycle with o_strobe; the receiver cannot stall, so
//   nothing backs up. When the heap empties, a done marker (o_merge_done) is
//   emitted and the block goes back to loading heads.
//   Configuration: i_cfg_data writes lane_count when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high.
// Sequencing:
//   An accepted item is inserted with a sift-up when it carries an element,
//   then, once merging, the root is popped with a sift-down (or a done marker
//   is sent); o_busy stays high throughout, so no new item is taken before the
//   last one is through. The single heap memory with its registered read
//   data sets this pace.
// Reset: synchronous, active low; heap empties, load phase, lane_count 16.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_merge_heap
    import kwmh_pkg::*;
#(
    parameter int LANES = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // item channel
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [3:0]                i_lane,
    input  wire logic                      i_has_element,
    input  wire logic signed [VALUE_W-1:0] i_value,
    // result channel
    output logic                           o_strobe,
    output logic signed [VALUE_W-1:0]      o_value_res,
    output logic [OUT_LANE_W-1:0]          o_lane_res,
    output logic                           o_has_value,
    output logic                           o_merge_done,
    // configuration channel
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_W-1:0]          i_cfg_data
);

    localparam int IW = $clog2(LANES);
    localparam int LW = IW;
    localparam int SW = $clog2(LANES + 1);
    localparam int KW = VALUE_W + LW;
    localparam int CW = IW + 2;

    // Key = {value with sign flipped, lane}: unsigned order is pop order.
    t_state          r_state, n_state;
    logic [SW-1:0]   r_size, n_size;
    logic [SW-1:0]   r_heads, n_heads;
    logic            r_merging, n_merging;
    logic [LW-1:0]   r_pending, n_pending;
    logic [KW-1:0]   r_key, n_key;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_do_pop, n_do_pop;
    logic [CFG_W-1:0] r_lane_count;

    logic                  r_strobe, n_strobe;
    logic [VALUE_W-1:0]    r_out_value, n_out_value;
    logic [OUT_LANE_W-1:0] r_out_lane, n_out_lane;
    logic                  r_out_has, n_out_has;
    logic                  r_out_done, n_out_done;

    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr0, mem_raddr1;
    logic [KW-1:0] mem_wdata, mem_rdata0, mem_rdata1;

    logic [SW-1:0] eff_count;
    logic [SW-1:0] heads_inc;
    logic [KW-1:0] new_key;
    logic [IW-1:0] parent_idx;
    logic [CW-1:0] left_idx, right_idx, size_ext;
    logic          left_ok, right_ok, take_right;
    logic [KW-1:0] child_key;
    logic [IW-1:0] child_idx;
    logic [IW-1:0] child_l, child_r;

    kwmh_heap_mem #(
        .DEPTH (LANES),
        .AW    (IW),
        .DW    (KW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr0 (mem_raddr0),
        .i_raddr1 (mem_raddr1),
        .o_rdata0 (mem_rdata0),
        .o_rdata1 (mem_rdata1)
    );

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_count <= LANE_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_lane_count <= i_cfg_data;
        end
    end

    // clamp lane count to 1..LANES
    always_comb begin
        if (int'(r_lane_count) > LANES) begin
            eff_count = SW'(LANES);
        end else if (r_lane_count == '0) begin
            eff_count = SW'(1);
        end else begin
            eff_count = SW'(r_lane_count);
        end
    end

    assign heads_inc  = r_heads + 1'b1;
    assign parent_idx = (r_idx - 1'b1) >> 1;
    assign left_idx   = {1'b0, r_idx, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign size_ext   = CW'(r_size);
    assign left_ok    = left_idx < size_ext;
    assign right_ok   = right_idx < size_ext;
    assign take_right = right_ok && (mem_rdata1 < mem_rdata0);
    assign child_key  = take_right ? mem_rdata1 : mem_rdata0;
    assign child_l    = left_idx[IW-1:0];
    assign child_r    = right_idx[IW-1:0];
    assign child_idx  = take_right ? child_r : child_l;

    always_comb begin
        new_key = {i_value ^ SIGN_FLIP, r_merging ? r_pending : LW'(r_heads)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size    <= '0;
            r_heads   <= '0;
            r_merging <= 1'b0;
            r_pending <= '0;
            r_do_pop  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_size    <= n_size;
            r_heads   <= n_heads;
            r_merging <= n_merging;
            r_pending <= n_pending;
            r_do_pop  <= n_do_pop;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_out_value <= n_out_value;
        r_out_lane  <= n_out_lane;
        r_out_has   <= n_out_has;
        r_out_done  <= n_out_done;
    end

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_heads     = r_heads;
        n_merging   = r_merging;
        n_pending   = r_pending;
        n_do_pop    = r_do_pop;
        n_key       = r_key;
        n_idx       = r_idx;
        n_strobe    = 1'b0;
        n_out_value = r_out_value;
        n_out_lane  = r_out_lane;
        n_out_has   = r_out_has;
        n_out_done  = r_out_done;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_key;
        mem_raddr0  = '0;
        mem_raddr1  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (r_merging) begin
                        n_do_pop = 1'b1;
                    end else begin
                        n_heads = heads_inc;
                        if (heads_inc >= eff_count) begin
                            n_do_pop  = 1'b1;
                            n_merging = 1'b1;
                        end else begin
                            n_do_pop = 1'b0;
                        end
                    end
                    if (i_has_element && (int'(r_size) < LANES)) begin
                        // insert at the end, then sift up
                        n_key      = new_key;
                        n_idx      = IW'(r_size);
                        n_size     = r_size + 1'b1;
                        mem_raddr0 = (IW'(r_size) - 1'b1) >> 1;
                        n_state    = (r_size == '0) ? S_PLACE : S_UP;
                    end else if (r_merging || (heads_inc >= eff_count)) begin
                        n_state = S_POP;
                    end
                end
            end
            S_UP: begin
                if (r_key < mem_rdata0) begin
                    // move parent down into the hole
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata0;
                    n_idx      = parent_idx;
                    mem_raddr0 = (parent_idx - 1'b1) >> 1;
                    n_state    = (parent_idx == '0) ? S_PLACE : S_UP;
                end else begin
                    mem_we  = 1'b1;
                    n_state = r_do_pop ? S_POP : S_IDLE;
                end
            end
            S_PLACE: begin
                mem_we  = 1'b1;
                n_state = r_do_pop ? S_POP : S_IDLE;
            end
            S_POP: begin
                if (r_size == '0) begin
                    // heap empty: done marker, back to loading
                    n_strobe    = 1'b1;
                    n_out_value = '0;
                    n_out_lane  = '0;
                    n_out_has   = 1'b0;
                    n_out_done  = 1'b1;
                    n_merging   = 1'b0;
                    n_heads     = '0;
                    n_pending   = '0;
                    n_state     = S_IDLE;
                end else begin
                    mem_raddr0 = '0;
                    mem_raddr1 = IW'(r_size - 1'b1);
                    n_size     = r_size - 1'b1;
                    n_state    = S_TOP;
                end
            end
            S_TOP: begin
                n_strobe    = 1'b1;
                n_out_value = mem_rdata0[KW-1:LW] ^ SIGN_FLIP;
                n_out_lane  = OUT_LANE_W'(mem_rdata0[LW-1:0]);
                n_out_has   = 1'b1;
                n_out_done  = 1'b0;
                n_pending   = mem_rdata0[LW-1:0];
                if (r_size == '0) begin
                    n_state = S_IDLE;
                end else begin
                    // last entry fills the root hole, sift down
                    n_key      = mem_rdata1;
                    n_idx      = '0;
                    mem_raddr0 = IW'(1);
                    mem_raddr1 = IW'(2);
                    n_state    = S_DN;
                end
            end
            S_DN: begin
                if (left_ok && (child_key < r_key)) begin
                    mem_we     = 1'b1;
                    mem_wdata  = child_key;
                    n_idx      = child_idx;
                    mem_raddr0 = IW'({child_idx, 1'b1});
                    mem_raddr1 = IW'({child_idx, 1'b1} + 1'b1);
                    n_state    = S_DN;
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_value_res  = r_out_value;
    assign o_lane_res   = r_out_lane;
    assign o_has_value  = r_out_has;
    assign o_merge_done = r_out_done;

endmodule

`default_nettype wire

@@ hdl/kwmh_heap_mem.sv @@
// ----------------------------------------------------------------------------
// kwmh_heap_mem
// Heap storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kwmh_heap_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 36
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic      [DW-1:0] o_rdata0,
    output logic      [DW-1:0] o_rdata1
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end

endmodule

`default_nettype wire

@@ bench/k_way_merge_heap_test.sv @@
// ----------------------------------------------------------------------------
// k_way_merge_heap_test
// Self-checking bench for the k-way merge heap. A short list of directed items
// covers the lane-count extremes, ties, absent heads and a lane count lowered
// mid-load. Random merges of sorted lists follow, mixed with scrambled items.
// Every strobed result is checked against a bench heap predictor or a typed-in one.
// ----------------------------------------------------------------------------
module k_way_merge_heap_test;
    import kwmh_pkg::*;

    localparam int LANE_MAX    = 16;
    localparam int MAX_LIST    = 12;
    localparam int ITEM_TARGET = 1650;
    localparam int TAIL_ITEMS  = 250;
    localparam int SETTLE      = 20;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TIMEOUT_TU  = 2_000_000;

    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [OUT_LANE_W-1:0]     lane;
        logic                      has_value;
        logic                      merge_done;
    } t_merge_out;

    typedef enum logic [1:0] {
        ROW_CFG,   // write lane_count
        ROW_ITEM,  // item checked against the predictor
        ROW_PIN    // item with its result typed in
    } t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [CFG_W-1:0]          cfg;
        logic [3:0]                lane;
        logic                      has;
        logic signed [VALUE_W-1:0] value;
        t_merge_out                res;
    } t_stim_row;

    localparam t_merge_out DONE_MARK = '{32'sd0, 4'd0, 1'b0, 1'b1};
    localparam int DIR_ROWS = 21;

    // Lane fields are junk on purpose: the block assigns lanes itself.
    t_stim_row directed_rows [DIR_ROWS] = '{
        '{ROW_CFG,  5'd0,  4'd0,  1'b0, 32'sd0,         DONE_MARK},
        '{ROW_PIN,  5'd0,  4'd15, 1'b1, V_MIN,          '{V_MIN, 4'd0, 1'b1, 1'b0}},
        '{ROW_PIN,  5'd0,  4'd9,  1'b1, V_MAX,          '{V_MAX, 4'd0, 1'b1, 1'b0}},
        '{ROW_PIN,  5'd0,  4'd0,  1'b0, 32'sh5A5A_A5A5, DONE_MARK},
        '{ROW_PIN,  5'd0,  4'd7,  1'b0, -32'sd1,        DONE_MARK},
        '{ROW_CFG,  5'd3,  4'd0,  1'b0, 32'sd0,         DONE_MARK},
        '{ROW_ITEM, 5'd0,  4'd3,  1'b1, 32'sd5,         DONE_MARK},
        '{ROW_ITEM, 5'd0,  4'd0,  1'b1, 32'sd5,         DONE_MARK},
        '{ROW_PIN,  5'd0,  4'd12, 1'b1, -32'sd1,        '{-32'sd1, 4'd2, 1'b1, 1'b0}},
        '{ROW_PIN,  5'd0,  4'd2,  1'b0, 32'sd0,         '{32'sd5, 4'd0, 1'b1, 1'b0}},
        '{ROW_PIN,  5'd0,  4'd0,  1'b1, 32'sd5,         '{32'sd5, 4'd0, 1'b1, 1'b0}},
        '{ROW_PIN,  5'd0,  4'd6,  1'b0, 32'sd0,         '{32'sd5, 4'd1, 1'b1, 1'b0}},
        '{ROW_PIN,  5'd0,  4'd1,  1'b0, 32'sd0,         DONE_MARK},
        '{ROW_CFG,  5'd4,  4'd0,  1'b0, 32'sd0,         DONE_MARK},
        '{ROW_ITEM, 5'd0,  4'd11, 1'b1, V_MAX,          DONE_MARK},
        '{ROW_ITEM, 5'd0,  4'd4,  1'b0, V_MIN,          DONE_MARK},
        '{ROW_CFG,  5'd2,  4'd0,  1'b0, 32'sd0,         DONE_MARK},
        '{ROW_ITEM, 5'd0,  4'd8,  1'b1, 32'sd0,         DONE_MARK},
        '{ROW_ITEM, 5'd0,  4'd5,  1'b0, 32'sd0,         DONE_MARK},
        '{ROW_ITEM, 5'd0,  4'd14, 1'b0, 32'sd0,         DONE_MARK},
        '{ROW_CFG,  5'd16, 4'd0,  1'b0, 32'sd0,         DONE_MARK}
    };

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_start       = 1'b0;
    logic [3:0]                i_lane        = '0;
    logic                      i_has_element = 1'b0;
    logic signed [VALUE_W-1:0] i_value       = '0;
    logic                      i_cfg_valid   = 1'b0;
    logic [CFG_W-1:0]          i_cfg_data    = '0;
    logic                      o_busy;
    logic                      o_strobe;
    logic signed [VALUE_W-1:0] o_value_res;
    logic [OUT_LANE_W-1:0]     o_lane_res;
    logic                      o_has_value;
    logic                      o_merge_done;
    logic                      o_cfg_ready;

    // typed-in result travels with the item like a port
    logic       pin_on  = 1'b0;
    t_merge_out pin_res = '0;

    k_way_merge_heap #(.LANES(LANE_MAX)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_lane        (i_lane),
        .i_has_element (i_has_element),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_value_res   (o_value_res),
        .o_lane_res    (o_lane_res),
        .o_has_value   (o_has_value),
        .o_merge_done  (o_merge_done),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Heap predictor
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] heap_val [LANE_MAX];
    logic [3:0]                heap_ln  [LANE_MAX];
    int                        heap_cnt;
    int                        heads_in;
    bit                        merging;
    logic [3:0]                refill_lane;
    logic [CFG_W-1:0]          lane_cfg;
    t_merge_out                merged_due [$];

    int items_sent, results_seen, merges_closed, cfg_writes, failures;
    int lanes_now = LANE_MAX;
    bit gaps_on;

    function automatic int active_lanes(logic [CFG_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > LANE_MAX)
            return LANE_MAX;
        return int'(n);
    endfunction

    // a pops out before b: lower value, then lower lane
    function automatic bit ahead(int a, int b);
        if (heap_val[a] != heap_val[b])
            return heap_val[a] < heap_val[b];
        return heap_ln[a] < heap_ln[b];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic signed [VALUE_W-1:0] tv;
        logic [3:0]                tl;
        tv = heap_val[a];
        heap_val[a] = heap_val[b];
        heap_val[b] = tv;
        tl = heap_ln[a];
        heap_ln[a] = heap_ln[b];
        heap_ln[b] = tl;
    endfunction

    function automatic void heap_insert(logic signed [VALUE_W-1:0] v, logic [3:0] ln);
        int i, p;
        if (heap_cnt >= LANE_MAX)
            return;  // drop on full
        i = heap_cnt;
        heap_cnt++;
        heap_val[i] = v;
        heap_ln[i] = ln;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!ahead(i, p))
                break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void heap_take(output logic signed [VALUE_W-1:0] v,
                                      output logic [3:0] ln);
        int i, l, r, m;
        v = heap_val[0];
        ln = heap_ln[0];
        heap_cnt--;
        if (heap_cnt == 0)
            return;
        heap_val[0] = heap_val[heap_cnt];
        heap_ln[0] = heap_ln[heap_cnt];
        i = 0;
        while (1) begin
            l = 2 * i + 1;
            r = l + 1;
            m = i;
            if (l < heap_cnt && ahead(l, m))
                m = l;
            if (r < heap_cnt && ahead(r, m))
                m = r;
            if (m == i)
                break;
            swap_slots(i, m);
            i = m;
        end
    endfunction

    function automatic void merge_step(input logic has, input logic signed [VALUE_W-1:0] v,
                                       output bit made, output t_merge_out res);
        logic signed [VALUE_W-1:0] pv;
        logic [3:0]                pl;
        made = 1'b0;
        res = '0;
        if (!merging) begin
            if (has)
                heap_insert(v, 4'(heads_in));
            heads_in++;
            if (heads_in < active_lanes(lane_cfg))
                return;
            merging = 1'b1;
        end else if (has) begin
            heap_insert(v, refill_lane);
        end
        made = 1'b1;
        if (heap_cnt == 0) begin
            res.merge_done = 1'b1;
            merging = 1'b0;
            heads_in = 0;
            refill_lane = '0;
        end else begin
            heap_take(pv, pl);
            refill_lane = pl;
            res.value = pv;
            res.lane = pl;
            res.has_value = 1'b1;
        end
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // check strobed results first, then predict the item taken at this edge
    always @(posedge i_clk) begin
        t_merge_out want;
        bit         made;
        if (!i_rst_n) begin
            heap_cnt = 0;
            heads_in = 0;
            merging = 1'b0;
            refill_lane = '0;
            lane_cfg = LANE_COUNT_RST;
            merged_due.delete();
        end else begin
            if (o_strobe === 1'b1) begin
                results_seen++;
                if (o_merge_done === 1'b1)
                    merges_closed++;
                if (merged_due.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result: value %h lane %0d has %b done %b",
                             $time, o_value_res, o_lane_res, o_has_value, o_merge_done);
                end else begin
                    want = merged_due.pop_front();
                    compare_field("value_res", want.value, o_value_res);
                    compare_field("lane_res", 32'(want.lane), 32'(o_lane_res));
                    compare_field("has_value", 32'(want.has_value), 32'(o_has_value));
                    compare_field("merge_done", 32'(want.merge_done), 32'(o_merge_done));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                lane_cfg = i_cfg_data;
            if (i_start && !o_busy) begin
                merge_step(i_has_element, i_value, made, want);
                if (made) begin
                    if (pin_on)
                        want = pin_res;
                    merged_due = {merged_due, want};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_item(input logic [3:0] ln, input logic has,
                             input logic signed [VALUE_W-1:0] v,
                             input logic pinned, input t_merge_out res);
        i_start <= 1'b1;
        i_lane <= ln;
        i_has_element <= has;
        i_value <= v;
        pin_on <= pinned;
        pin_res <= res;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        items_sent++;
        if (gaps_on && items_sent < ITEM_TARGET - TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // hold off until nothing is in flight
    task automatic settle();
        i_start <= 1'b0;
        do @(negedge i_clk); while (merged_due.size() != 0 || o_busy !== 1'b0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_lane_count(input logic [CFG_W-1:0] n);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        lanes_now = active_lanes(n);
        cfg_writes++;
    endtask

    function automatic logic [CFG_W-1:0] pick_lane_count();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'($urandom_range(17, 31));
            4:       return 5'($urandom_range(9, 15));
            default: return 5'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value(int mode);
        case (mode)
            0: return $urandom;
            1: return int'($urandom_range(0, 8)) - 4;
            default: begin
                case ($urandom_range(0, 6))
                    0:       return V_MIN;
                    1:       return V_MIN + 1;
                    2:       return -32'sd1;
                    3:       return 32'sd0;
                    4:       return 32'sd1;
                    5:       return V_MAX - 1;
                    default: return V_MAX;
                endcase
            end
        endcase
    endfunction

    // drop leftover heads and heap contents until the block is back at load
    task automatic return_to_load();
        settle();
        while (merging || heads_in != 0) begin
            send_item(4'($urandom), 1'b0, pick_value(0), 1'b0, '0);
            settle();
        end
    endtask

    // one well-formed merge: sorted lists, heads in lane order, proper refills
    task automatic run_merge(input int k);
        logic signed [VALUE_W-1:0] lst [LANE_MAX][MAX_LIST];
        int                        len [LANE_MAX];
        int                        at  [LANE_MAX];
        logic signed [VALUE_W-1:0] t;
        int                        mode, longest, m, j;
        mode = $urandom_range(0, 2);
        longest = ($urandom_range(0, 7) == 0) ? MAX_LIST : 4;
        for (int l = 0; l < k; l++) begin
            len[l] = $urandom_range(0, longest);
            at[l] = 0;
            for (int i = 0; i < len[l]; i++) begin
                t = pick_value(mode);
                j = i;
                while (j > 0 && lst[l][j-1] > t) begin
                    lst[l][j] = lst[l][j-1];
                    j--;
                end
                lst[l][j] = t;
            end
        end
        for (int l = 0; l < k; l++)
            send_item(4'($urandom), len[l] != 0, (len[l] != 0) ? lst[l][0] : pick_value(0),
                      1'b0, '0);
        // follow the merge order: smallest head, lower lane on ties
        while (1) begin
            m = -1;
            for (int l = 0; l < k; l++)
                if (at[l] < len[l] && (m < 0 || lst[l][at[l]] < lst[m][at[m]]))
                    m = l;
            if (m < 0)
                break;
            at[m]++;
            if (at[m] < len[m])
                send_item(4'($urandom), 1'b1, lst[m][at[m]], 1'b0, '0);
            else
                send_item(4'($urandom), 1'b0, pick_value(0), 1'b0, '0);
        end
    endtask

    // random items with no regard to lane order, sometimes a lane count change mid-way
    task automatic scramble();
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2 && $urandom_range(0, 2) == 0)
                write_lane_count(pick_lane_count());
            send_item(4'($urandom), 1'($urandom_range(0, 1)),
                      pick_value($urandom_range(0, 2)), 1'b0, '0);
        end
        return_to_load();
    endtask

    initial begin
        int waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gaps_on = 1'b1;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_lane_count(directed_rows[r].cfg);
            else
                send_item(directed_rows[r].lane, directed_rows[r].has, directed_rows[r].value,
                          directed_rows[r].kind == ROW_PIN, directed_rows[r].res);
        end
        settle();

        while (items_sent < ITEM_TARGET) begin
            gaps_on = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 2) == 0)
                write_lane_count(pick_lane_count());
            if ($urandom_range(0, 9) < 8)
                run_merge(lanes_now);
            else
                scramble();
        end

        i_start <= 1'b0;
        waited = 0;
        while (merged_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(negedge i_clk);
        if (merged_due.size() != 0) begin
            failures += merged_due.size();
            $display("%0t: %0d expected results never arrived", $time, merged_due.size());
        end
        $display("Sent %0d items (%0d directed rows), checked %0d results", items_sent,
                 DIR_ROWS, results_seen);
        $display("Closed %0d merges across %0d lane-count writes, %0d mismatches",
                 merges_closed, cfg_writes, failures);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_TU);
        $display("%0t: timeout, %0d items sent, %0d results pending", $time, items_sent,
                 merged_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
